// File: rtl/swpf_pkg.sv
// Package for the servo write packet framer.
// Holds the opcode, byte-source and jump codes, the control word type, the
// microcode table and the CRC-16 byte update. No dependencies.
`default_nettype none

package swpf_pkg;

   typedef logic [3:0] step_type;
   typedef logic [3:0] src_type;
   typedef logic [1:0] jump_type;
   typedef logic [1:0] ndata_type;

   localparam logic [2:0] OP_MODE   = 3'd0;
   localparam logic [2:0] OP_POS    = 3'd1;
   localparam logic [2:0] OP_PWM    = 3'd2;
   localparam logic [2:0] OP_LED    = 3'd3;
   localparam logic [2:0] OP_TORQUE = 3'd4;

   localparam src_type SRC_FF     = 4'd0;
   localparam src_type SRC_FD     = 4'd1;
   localparam src_type SRC_ZERO   = 4'd2;
   localparam src_type SRC_ID     = 4'd3;
   localparam src_type SRC_LEN    = 4'd4;
   localparam src_type SRC_INSTR  = 4'd5;
   localparam src_type SRC_ADDR   = 4'd6;
   localparam src_type SRC_DATA0  = 4'd7;
   localparam src_type SRC_DATA1  = 4'd8;
   localparam src_type SRC_CRC_LO = 4'd9;
   localparam src_type SRC_CRC_HI = 4'd10;

   localparam jump_type JMP_NONE   = 2'd0;
   localparam jump_type JMP_IF_ONE = 2'd1;
   localparam jump_type JMP_IF_TWO = 2'd2;

   localparam ndata_type NDATA_ONE  = 2'd0;
   localparam ndata_type NDATA_TWO  = 2'd1;
   localparam ndata_type NDATA_FOUR = 2'd2;

   localparam logic [7:0] BYTE_HDR   = 8'hFF;
   localparam logic [7:0] BYTE_HDR3  = 8'hFD;
   localparam logic [7:0] BYTE_WRITE = 8'h03;
   localparam logic [7:0] ADDR_MODE  = 8'h0B;
   localparam logic [7:0] ADDR_POS   = 8'h74;
   localparam logic [7:0] ADDR_PWM   = 8'h64;
   localparam logic [7:0] ADDR_LED   = 8'h41;
   localparam logic [7:0] ADDR_TORQ  = 8'h40;
   localparam logic [7:0] MODE_PWM   = 8'h10;
   localparam logic [7:0] MODE_POS   = 8'h03;
   localparam logic [7:0] SERVO_ID_RESET = 8'h01;
   localparam logic [15:0] CRC_POLY  = 16'h8005;

   typedef struct packed {
      src_type  src;
      logic     crc_en;
      logic     last;
      jump_type jump;
      step_type target;
   } uword_type;

   function automatic uword_type ucode_rom(input step_type step);
      uword_type w;
      w = '{src: SRC_ZERO, crc_en: 1'b1, last: 1'b0, jump: JMP_NONE, target: 4'd0};
      case (step)
         4'd0:  w.src = SRC_FF;
         4'd1:  w.src = SRC_FF;
         4'd2:  w.src = SRC_FD;
         4'd3:  w.src = SRC_ZERO;
         4'd4:  w.src = SRC_ID;
         4'd5:  w.src = SRC_LEN;
         4'd6:  w.src = SRC_ZERO;
         4'd7:  w.src = SRC_INSTR;
         4'd8:  w.src = SRC_ADDR;
         4'd9:  w.src = SRC_ZERO;
         4'd10: begin
            w.src    = SRC_DATA0;
            w.jump   = JMP_IF_ONE;
            w.target = 4'd14;
         end
         4'd11: begin
            w.src    = SRC_DATA1;
            w.jump   = JMP_IF_TWO;
            w.target = 4'd14;
         end
         4'd12: w.src = SRC_ZERO;
         4'd13: w.src = SRC_ZERO;
         4'd14: begin
            w.src    = SRC_CRC_LO;
            w.crc_en = 1'b0;
         end
         4'd15: begin
            w.src    = SRC_CRC_HI;
            w.crc_en = 1'b0;
            w.last   = 1'b1;
         end
         default: w.src = SRC_ZERO;
      endcase
      return w;
   endfunction

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: rtl/swpf_sequencer.sv
// Microcode sequencer of the servo write packet framer.
// Steps through the control table in swpf_pkg, one beat per step, with
// conditional jumps on the data length. Depends on swpf_pkg.
`default_nettype none

module swpf_sequencer (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  wire                 out_free,
   input  swpf_pkg::ndata_type ndata,
   output logic                busy,
   output logic                fire,
   output swpf_pkg::uword_type uword
);
   import swpf_pkg::*;

   step_type step_ff, step_in;
   logic     busy_ff, busy_in;
   logic     jump_taken;

   assign uword = ucode_rom(step_ff);
   assign busy  = busy_ff;
   assign fire  = busy_ff & out_free;

   assign jump_taken = ((uword.jump == JMP_IF_ONE) && (ndata == NDATA_ONE)) ||
                       ((uword.jump == JMP_IF_TWO) && (ndata == NDATA_TWO));

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         step_in = 4'd0;
         busy_in = 1'b1;
      end else if (fire) begin
         if (uword.last) begin
            busy_in = 1'b0;
         end else if (jump_taken) begin
            step_in = uword.target;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 4'd0;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/swpf_datapath.sv
// Datapath of the servo write packet framer.
// Holds the command fields, the servo id register, the CRC and the output
// register, and selects each packet byte as the control word says. Depends on swpf_pkg.
`default_nettype none

module swpf_datapath (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 load,
   input  wire  [2:0]          opcode,
   input  wire                 mode_select,
   input  wire  [11:0]         goal_position,
   input  wire  signed [10:0]  goal_pwm,
   input  wire                 flag_on,
   input  wire                 csr_wr_en,
   input  wire  [7:0]          csr_wr_data,
   input  wire                 fire,
   input  swpf_pkg::uword_type uword,
   input  wire                 rsp_stall,
   output swpf_pkg::ndata_type ndata,
   output logic                out_free,
   output logic                rsp_valid,
   output logic [7:0]          rsp_frame_byte,
   output logic                rsp_last_byte
);
   import swpf_pkg::*;

   localparam logic signed [10:0] PwmLimit = 11'sd885;
   localparam logic signed [10:0] PwmFloor = -11'sd885;

   logic [7:0]  servo_id_ff, servo_id_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  data0_ff, data0_in;
   logic [7:0]  data1_ff, data1_in;
   logic [7:0]  len_ff, len_in;
   ndata_type   ndata_ff, ndata_in;
   logic [15:0] crc_ff, crc_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic signed [10:0] pwm_clamped;
   logic [15:0] pwm16;
   logic [7:0]  cur_byte;

   assign ndata          = ndata_ff;
   assign out_free       = ~valid_ff | ~rsp_stall;
   assign rsp_valid      = valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_last_byte  = last_ff;

   always_comb begin
      if (goal_pwm > PwmLimit) begin
         pwm_clamped = PwmLimit;
      end else if (goal_pwm < PwmFloor) begin
         pwm_clamped = PwmFloor;
      end else begin
         pwm_clamped = goal_pwm;
      end
      pwm16 = {{5{pwm_clamped[10]}}, pwm_clamped};
   end

   always_comb begin
      addr_in  = addr_ff;
      data0_in = data0_ff;
      data1_in = data1_ff;
      len_in   = len_ff;
      ndata_in = ndata_ff;
      if (load) begin
         data1_in = 8'h00;
         case (opcode)
            OP_MODE: begin
               addr_in  = ADDR_MODE;
               data0_in = mode_select ? MODE_POS : MODE_PWM;
               len_in   = 8'd6;
               ndata_in = NDATA_ONE;
            end
            OP_POS: begin
               addr_in  = ADDR_POS;
               data0_in = goal_position[7:0];
               data1_in = {4'h0, goal_position[11:8]};
               len_in   = 8'd9;
               ndata_in = NDATA_FOUR;
            end
            OP_PWM: begin
               addr_in  = ADDR_PWM;
               data0_in = pwm16[7:0];
               data1_in = pwm16[15:8];
               len_in   = 8'd7;
               ndata_in = NDATA_TWO;
            end
            OP_LED: begin
               addr_in  = ADDR_LED;
               data0_in = {7'h00, flag_on};
               len_in   = 8'd6;
               ndata_in = NDATA_ONE;
            end
            default: begin
               addr_in  = ADDR_TORQ;
               data0_in = {7'h00, flag_on};
               len_in   = 8'd6;
               ndata_in = NDATA_ONE;
            end
         endcase
      end
   end

   always_comb begin
      case (uword.src)
         SRC_FF:     cur_byte = BYTE_HDR;
         SRC_FD:     cur_byte = BYTE_HDR3;
         SRC_ID:     cur_byte = servo_id_ff;
         SRC_LEN:    cur_byte = len_ff;
         SRC_INSTR:  cur_byte = BYTE_WRITE;
         SRC_ADDR:   cur_byte = addr_ff;
         SRC_DATA0:  cur_byte = data0_ff;
         SRC_DATA1:  cur_byte = data1_ff;
         SRC_CRC_LO: cur_byte = crc_ff[7:0];
         SRC_CRC_HI: cur_byte = crc_ff[15:8];
         default:    cur_byte = 8'h00;
      endcase
   end

   always_comb begin
      crc_in = crc_ff;
      if (load) begin
         crc_in = 16'h0000;
      end else if (fire && uword.crc_en) begin
         crc_in = crc_update(crc_ff, cur_byte);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (fire) begin
         valid_in = 1'b1;
         byte_in  = cur_byte;
         last_in  = uword.last;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   assign servo_id_in = csr_wr_en ? csr_wr_data : servo_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         servo_id_ff <= SERVO_ID_RESET;
         valid_ff    <= 1'b0;
      end else begin
         servo_id_ff <= servo_id_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      data0_ff <= data0_in;
      data1_ff <= data1_in;
      len_ff   <= len_in;
      ndata_ff <= ndata_in;
      crc_ff   <= crc_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
   end

endmodule

`default_nettype wire

// File: rtl/servo_write_packet_framer.sv
// Servo write packet framer: one write command in, one 13 to 16 byte packet out.
// The first beat enters the output register after the command loads the step counter and busy flag,
// then one beat per cycle while the output is not stalled; the microcode step counter sets this.
// A new command is taken once the last beat is in the output register.
// Synchronous reset sets the servo id to 1 and leaves the framer idle with no output pending.
// Depends on swpf_pkg, swpf_sequencer and swpf_datapath.
`default_nettype none

module servo_write_packet_framer (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire  [2:0]        req_opcode,
   input  wire               req_mode_select,
   input  wire  [11:0]       req_goal_position,
   input  wire  signed [10:0] req_goal_pwm,
   input  wire               req_flag_on,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic [7:0]        rsp_frame_byte,
   output logic              rsp_last_byte,
   input  wire               csr_wr_en,
   input  wire  [7:0]        csr_wr_data
);
   import swpf_pkg::*;

   logic      busy;
   logic      fire;
   logic      out_free;
   logic      accept;
   logic      start;
   uword_type uword;
   ndata_type ndata;

   assign req_stall = busy;
   assign accept    = req_valid & ~busy;
   // Unused opcodes are taken and produce no packet.
   assign start     = accept & (req_opcode <= OP_TORQUE);

   swpf_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .ndata    (ndata),
      .busy     (busy),
      .fire     (fire),
      .uword    (uword)
   );

   swpf_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .load           (start),
      .opcode         (req_opcode),
      .mode_select    (req_mode_select),
      .goal_position  (req_goal_position),
      .goal_pwm       (req_goal_pwm),
      .flag_on        (req_flag_on),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fire           (fire),
      .uword          (uword),
      .rsp_stall      (rsp_stall),
      .ndata          (ndata),
      .out_free       (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

`default_nettype wire
